FILE: rtl/gbte_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gbte_pkg
// Shared types and constants for the gap-buffer text store.
// ============================================================================
package gbte_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int POS_W = 11;
    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_MOVE   = 3'd2,
        OP_UP     = 3'd3,
        OP_DOWN   = 3'd4,
        OP_READ   = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_BAD    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RDATA,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/gap_buffer_text_editor_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// gap_buffer_text_editor_unit
// Gap-buffer text store with one cursor, one command per transfer.
// ============================================================================
// Usage:
//  Slave channel carries one command per transfer: tdata holds opcode,
//  char_in, distance, read_index. Master channel returns one result per
//  command: tdata holds status, char_out, cursor_pos, text_length.
//  The text lives in a single-port memory of DEPTH bytes. Insert, delete,
//  clear and bad commands need no memory read; read makes one memory
//  read. A cursor move copies one byte at a time through the memory
//  port, reading it and then writing it across the gap. Line up/down scan
//  one entry at a time (up to DEPTH-1 entries), then copy like a move;
//  all of these steps share the single memory port.
//  The block takes one command at a time; s_axis_tready is low while a
//  command runs and while its result waits. A stalled receiver simply
//  holds the result register. Reset empties the text (no clearing pass:
//  the memory is undefined until written and never read unwritten).
// ============================================================================
module gap_buffer_text_editor_unit #(
    parameter int DEPTH = gbte_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [10:3] char_in, [22:11] distance, [32:23] read_index
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] status, [8:1] char_out, [19:9] cursor_pos, [30:20] text_length
    output logic [31:0] m_axis_tdata
);
    import gbte_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int TW = (CW + 2 > 13) ? CW + 2 : 13;

    t_state r_state, n_state;
    logic [CW-1:0] r_front, n_front, r_back, n_back, r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;       // scan index / read address
    logic [CW-1:0] r_rem, n_rem;
    logic          r_dir, n_dir;       // 1: cursor moves right
    t_op           r_op, n_op;
    logic          r_st, n_st;
    logic [7:0]    r_cout, n_cout;
    logic          r_ovalid, n_ovalid;

    // memory
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wd;
    logic          mem_re;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_addr];
    end

    // input fields
    t_op               in_op;
    logic [7:0]        in_ch;
    logic signed [12:0] in_dist;
    logic [9:0]        in_ridx;
    logic signed [TW-1:0] tgt;
    logic [CW-1:0]     ridx_w, abs_d;
    assign in_op   = t_op'(s_axis_tdata[2:0]);
    assign in_ch   = s_axis_tdata[10:3];
    assign in_dist = 13'(signed'(s_axis_tdata[22:11]));
    assign in_ridx = s_axis_tdata[32:23];
    assign tgt     = TW'(signed'({2'b00, r_front})) + TW'(in_dist);
    assign abs_d   = in_dist[12] ? CW'(-in_dist) : CW'(in_dist);
    assign ridx_w  = CW'(in_ridx);

    assign s_axis_tready = (r_state == ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_front  <= '0;
            r_back   <= CW'(DEPTH);
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_idx <= n_idx; r_rem <= n_rem; r_dir <= n_dir; r_op <= n_op;
        r_st <= n_st; r_cout <= n_cout;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_front = r_front; n_back = r_back; n_count = r_count;
        n_idx = r_idx; n_rem = r_rem; n_dir = r_dir; n_op = r_op;
        n_st = r_st; n_cout = r_cout; n_ovalid = r_ovalid;
        mem_addr = r_idx[AW-1:0]; mem_we = 1'b0; mem_wd = r_rd; mem_re = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_st = 1'b0; n_cout = 8'd0; n_state = ST_OUT;
                    n_op = in_op;
                    case (in_op)
                        OP_INSERT: begin
                            if (in_ch == 8'd0 || r_count >= CW'(DEPTH)) n_st = 1'b1;
                            else begin
                                mem_addr = r_front[AW-1:0]; mem_we = 1'b1;
                                mem_wd = in_ch;
                                n_front = r_front + 1'b1; n_count = r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (r_front == '0) n_st = 1'b1;
                            else begin
                                n_front = r_front - 1'b1; n_count = r_count - 1'b1;
                            end
                        end
                        OP_MOVE: begin
                            if (in_dist == '0 || tgt < 0 ||
                                tgt > TW'(signed'({2'b00, r_count})))
                                n_st = 1'b1;
                            else begin
                                n_dir = ~in_dist[12]; n_rem = abs_d;
                                n_state = ST_COPY_RD;
                            end
                        end
                        OP_UP: begin
                            if (r_front > CW'(1)) begin
                                n_idx = r_front - 1'b1; n_state = ST_SCAN;
                            end
                        end
                        OP_DOWN: begin
                            if (r_front != r_count && r_back + 1'b1 < CW'(DEPTH)) begin
                                n_idx = r_back + 1'b1; n_state = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (ridx_w >= r_count) n_st = 1'b1;
                            else begin
                                n_idx = (ridx_w < r_front) ? ridx_w
                                        : r_back + (ridx_w - r_front);
                                n_state = ST_RDATA;
                            end
                        end
                        OP_CLEAR: begin
                            n_front = '0; n_back = CW'(DEPTH); n_count = '0;
                        end
                        default: n_st = 1'b1;
                    endcase
                end
            end
            // issue a read of r_idx, check it next cycle
            ST_SCAN: begin
                mem_re = 1'b1; n_state = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                if (r_rd == NEWLINE) begin
                    n_dir = (r_op == OP_DOWN);
                    n_rem = (r_op == OP_DOWN) ? r_idx - r_back : r_front - r_idx;
                    n_state = ST_COPY_RD;
                end else if (r_op == OP_UP) begin
                    if (r_idx == CW'(1)) n_state = ST_OUT;
                    else begin n_idx = r_idx - 1'b1; n_state = ST_SCAN; end
                end else begin
                    if (r_idx + 1'b1 >= CW'(DEPTH)) n_state = ST_OUT;
                    else begin n_idx = r_idx + 1'b1; n_state = ST_SCAN; end
                end
            end
            // one byte across the gap: read then write
            ST_COPY_RD: begin
                if (r_rem == '0) n_state = ST_OUT;
                else begin
                    mem_re = 1'b1;
                    mem_addr = r_dir ? r_back[AW-1:0] : AW'(r_front - 1'b1);
                    n_state = ST_COPY_WR;
                end
            end
            ST_COPY_WR: begin
                mem_we = 1'b1;
                if (r_dir) begin
                    mem_addr = r_front[AW-1:0];
                    n_front = r_front + 1'b1; n_back = r_back + 1'b1;
                end else begin
                    mem_addr = AW'(r_back - 1'b1);
                    n_front = r_front - 1'b1; n_back = r_back - 1'b1;
                end
                n_rem = r_rem - 1'b1; n_state = ST_COPY_RD;
            end
            // read data lands in r_rd for the output stage
            ST_RDATA: begin
                mem_re = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid) begin
                    if (r_op == OP_READ && !r_st) n_cout = r_rd;
                    n_ovalid = 1'b1;
                end else if (m_axis_tready) begin
                    n_ovalid = 1'b0; n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, POS_W'(r_count), POS_W'(r_front), r_cout, r_st};

    // checks
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_count) else $error("cursor beyond text");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_back) + 32'(r_count) - 32'(r_front)) == 32'(DEPTH))
        else $error("gap regions inconsistent");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
endmodule
